/* rtl/core/lzu_pkg.sv */
// Package: shared types and constants of the unary-code LZ decompressor.
`timescale 1ns / 1ps
package lzu_pkg;

    localparam int WINDOW_SIZE_DEF = 16384;
    localparam int LEN_PREFIX_MAX  = 7;
    localparam int OFF_PREFIX_MAX  = 4;
    localparam int OFF_BITS_BASE   = 9;
    localparam int OFF_BIAS        = 512;

    typedef enum logic [1:0] {
        ST_DATA      = 2'd0,
        ST_DONE      = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_LEN_PREFIX = 3'd0,
        PH_LEN_SKIP   = 3'd1,
        PH_LEN_BITS   = 3'd2,
        PH_LITERAL    = 3'd3,
        PH_OFF_PREFIX = 3'd4,
        PH_OFF_SKIP   = 3'd5,
        PH_OFF_BITS   = 3'd6,
        PH_DONE       = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_BITS    = 3'd1,
        S_COPY_RD = 3'd2,
        S_COPY_WR = 3'd3,
        S_REPORT  = 3'd4
    } t_state;

    // decoder status toward the sequencer
    typedef struct packed {
        logic        lit_next;   // next bit completes a literal
        logic        match_next; // next bit completes the offset
        logic        end_ok;     // an end beat now reports done
        logic        is_done;    // decoder in done phase
        logic [7:0]  lit_byte;   // literal byte if the next bit completes it
        logic [8:0]  len;        // match length
        logic [13:0] distance;   // match distance
    } t_dec_stat;

endpackage

/* rtl/core/lzu_bitdec.sv */
// Bit-serial code decoder: prefixes, length bits, literal and offset bits.
`timescale 1ns / 1ps
module lzu_bitdec (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_legacy_skip,
    input  logic               i_step,
    input  logic               i_bit,
    input  logic               i_end,
    output lzu_pkg::t_dec_stat o_stat
);

    lzu_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_ones, n_ones;
    logic [3:0]  r_cnt, n_cnt;
    logic [12:0] r_acc, n_acc, w_acc;
    logic [8:0]  r_len, n_len;
    logic [13:0] r_dist, n_dist;
    logic        r_any, n_any;
    logic [3:0]  w_nbits;
    logic        w_end_ok;

    assign w_acc   = {r_acc[11:0], i_bit};
    assign w_nbits = 4'(lzu_pkg::OFF_BITS_BASE) + {1'b0, r_ones};
    assign w_end_ok = (r_phase == lzu_pkg::PH_LEN_PREFIX) || (r_phase == lzu_pkg::PH_DONE) ||
                      ((r_phase == lzu_pkg::PH_LITERAL) && r_any);

    always_comb begin
        o_stat.lit_next   = (r_phase == lzu_pkg::PH_LITERAL) && (r_cnt == 4'd7);
        o_stat.match_next = (r_phase == lzu_pkg::PH_OFF_BITS) && ((r_cnt + 4'd1) == w_nbits);
        o_stat.end_ok     = w_end_ok;
        o_stat.is_done    = (r_phase == lzu_pkg::PH_DONE);
        o_stat.lit_byte   = w_acc[7:0];
        o_stat.len        = r_len;
        o_stat.distance   = r_dist;
    end

    always_comb begin
        n_phase = r_phase;
        n_ones  = r_ones;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_len   = r_len;
        n_dist  = r_dist;
        n_any   = r_any;
        if (i_end) begin
            if (w_end_ok) begin
                n_phase = lzu_pkg::PH_DONE;
            end
        end else if (i_step) begin
            case (r_phase)
                lzu_pkg::PH_LEN_PREFIX: begin
                    if (!i_bit) begin
                        n_phase = (r_ones == 3'd0) ? lzu_pkg::PH_LITERAL : lzu_pkg::PH_LEN_BITS;
                    end else begin
                        n_ones = r_ones + 3'd1;
                        if (n_ones == 3'(lzu_pkg::LEN_PREFIX_MAX)) begin
                            n_phase = i_legacy_skip ? lzu_pkg::PH_LEN_SKIP
                                                    : lzu_pkg::PH_LEN_BITS;
                        end
                    end
                end
                lzu_pkg::PH_LEN_SKIP: n_phase = lzu_pkg::PH_LEN_BITS;
                lzu_pkg::PH_LEN_BITS: begin
                    n_acc = w_acc;
                    n_cnt = r_cnt + 4'd1;
                    if (n_cnt == {1'b0, r_ones}) begin
                        n_len   = (9'd1 << r_ones) + 9'd1 + 9'(w_acc[6:0]);
                        n_ones  = 3'd0;
                        n_phase = lzu_pkg::PH_OFF_PREFIX;
                    end
                end
                lzu_pkg::PH_LITERAL: begin
                    n_acc = w_acc;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd7) begin
                        n_any   = 1'b1;
                        n_ones  = 3'd0;
                        n_phase = lzu_pkg::PH_LEN_PREFIX;
                    end
                end
                lzu_pkg::PH_OFF_PREFIX: begin
                    if (!i_bit) begin
                        n_phase = lzu_pkg::PH_OFF_BITS;
                    end else begin
                        n_ones = r_ones + 3'd1;
                        if (n_ones == 3'(lzu_pkg::OFF_PREFIX_MAX)) begin
                            n_phase = i_legacy_skip ? lzu_pkg::PH_OFF_SKIP
                                                    : lzu_pkg::PH_OFF_BITS;
                        end
                    end
                end
                lzu_pkg::PH_OFF_SKIP: n_phase = lzu_pkg::PH_OFF_BITS;
                lzu_pkg::PH_OFF_BITS: begin
                    n_acc = w_acc;
                    n_cnt = r_cnt + 4'd1;
                    if (n_cnt == w_nbits) begin
                        n_dist  = (14'd1 << w_nbits) - 14'(lzu_pkg::OFF_BIAS) + 14'(w_acc);
                        n_any   = 1'b1;
                        n_ones  = 3'd0;
                        n_phase = lzu_pkg::PH_LEN_PREFIX;
                    end
                end
                default: n_phase = r_phase;
            endcase
            // clear the bit collector on every phase change made by a step
            if (n_phase != r_phase) begin
                n_cnt = 4'd0;
                n_acc = 13'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lzu_pkg::PH_LEN_PREFIX;
            r_ones  <= 3'd0;
            r_cnt   <= 4'd0;
            r_acc   <= 13'd0;
            r_len   <= 9'd0;
            r_dist  <= 14'd0;
            r_any   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ones  <= n_ones;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_len   <= n_len;
            r_dist  <= n_dist;
            r_any   <= n_any;
        end
    end

endmodule

/* rtl/core/lzu_hist.sv */
// History window: ring memory with write pointer and fill tracking.
`timescale 1ns / 1ps
module lzu_hist #(
    parameter int WINDOW_SIZE = lzu_pkg::WINDOW_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [7:0]  i_wr_data,
    input  logic        i_rd_en,
    input  logic [13:0] i_dist,
    output logic [7:0]  o_rd_data
);

    localparam int AW = $clog2(WINDOW_SIZE);

    logic [7:0]    r_mem [WINDOW_SIZE];
    logic [AW-1:0] r_wp;
    logic          r_wrap;
    logic [7:0]    r_rd;
    logic          r_rd_zero;
    logic [AW+1:0] w_sum;
    logic [AW-1:0] w_src;

    // source = (wp - dist - 1) mod window
    assign w_sum = {2'b00, r_wp} + (AW+2)'(WINDOW_SIZE) - (AW+2)'(i_dist) - (AW+2)'(1);
    assign w_src = (w_sum >= (AW+2)'(WINDOW_SIZE)) ? AW'(w_sum - (AW+2)'(WINDOW_SIZE))
                                                   : AW'(w_sum);
    assign o_rd_data = r_rd_zero ? 8'd0 : r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wp] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd      <= r_mem[w_src];
            r_rd_zero <= !r_wrap && (w_src >= r_wp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_wrap <= 1'b0;
        end else if (i_wr_en) begin
            if (r_wp == AW'(WINDOW_SIZE - 1)) begin
                r_wp   <= '0;
                r_wrap <= 1'b1;
            end else begin
                r_wp <= r_wp + AW'(1);
            end
        end
    end

endmodule

/* rtl/core/lz_unary_code_decompressor_core.sv */
// Top level: unary-code LZ decompressor with stream ports and output packing.
`timescale 1ns / 1ps
// Usage:
//   Slave stream takes one compressed byte per beat (tdata[7:0]); tuser high
//   marks an end-of-input beat instead. Master stream returns results: tdata
//   holds up to eight output bytes (low byte first) and the byte count above
//   them, tlast marks the final beat of a literal, a match or an end report,
//   tuser carries the status (data, done, underflow).
//   The config channel writes the legacy skip bit; write it only while idle.
// Flow:
//   A byte beat is accepted only while idle; its bits are then decoded one
//   by one, and no new byte beat is taken before they are through. A match
//   copies each byte by a history read, then a write and pack. An end beat
//   is accepted, then reported once the output register is free. A literal
//   result is registered as its last bit is decoded.
// Reset:
//   Synchronous, active low. History reads as zeros until written (a fill
//   mark stands in for clearing), so the block is ready right after reset.
// Stall:
//   When the receiver holds tready low, the output register keeps its beat;
//   decoding goes on until the next result needs the register, then holds.
module lz_unary_code_decompressor_core #(
    parameter int WINDOW_SIZE = lzu_pkg::WINDOW_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,    // [0] legacy skip flag
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // [0] req_type
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // [63:0] out_bytes, [67:64] byte_count, zero pad
    output logic        m_axis_tlast,  // last_of_code
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    lzu_pkg::t_state    r_state, n_state;
    lzu_pkg::t_dec_stat w_dec;
    lzu_pkg::t_status   r_rep, n_rep;

    logic        r_old;
    logic [7:0]  r_sh, n_sh;
    logic [3:0]  r_bits, n_bits;
    logic [8:0]  r_rem, n_rem;
    logic [63:0] r_pk, n_pk, w_pk_ins;
    logic [2:0]  r_pkn, n_pkn;

    logic        r_ovalid, n_ovalid;
    logic [63:0] r_obytes, n_obytes;
    logic [3:0]  r_ocnt, n_ocnt;
    logic        r_olast, n_olast;
    lzu_pkg::t_status r_ostat, n_ostat;

    logic        w_out_free, w_in_acc, w_step, w_end;
    logic        w_wr_en, w_rd_en;
    logic [7:0]  w_wr_data, w_rd_data;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == lzu_pkg::S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ovalid || m_axis_tready;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_ocnt, r_obytes};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ostat;

    // insert the fetched history byte at the packing slot
    always_comb begin
        w_pk_ins = r_pk;
        w_pk_ins[{r_pkn, 3'b000} +: 8] = w_rd_data;
    end

    lzu_bitdec u_bitdec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_legacy_skip (r_old),
        .i_step        (w_step),
        .i_bit         (r_sh[7]),
        .i_end         (w_end),
        .o_stat        (w_dec)
    );

    lzu_hist #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_dist    (w_dec.distance),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state  = r_state;
        n_rep    = r_rep;
        n_sh     = r_sh;
        n_bits   = r_bits;
        n_rem    = r_rem;
        n_pk     = r_pk;
        n_pkn    = r_pkn;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_obytes = r_obytes;
        n_ocnt   = r_ocnt;
        n_olast  = r_olast;
        n_ostat  = r_ostat;
        w_step   = 1'b0;
        w_end    = 1'b0;
        w_wr_en  = 1'b0;
        w_wr_data = w_dec.lit_byte;
        w_rd_en  = 1'b0;
        case (r_state)
            lzu_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser) begin
                        // end beat: decide status now, report when register frees
                        w_end   = 1'b1;
                        n_rep   = w_dec.end_ok ? lzu_pkg::ST_DONE : lzu_pkg::ST_UNDERFLOW;
                        n_state = lzu_pkg::S_REPORT;
                    end else if (!w_dec.is_done) begin
                        n_sh    = s_axis_tdata;
                        n_bits  = 4'd8;
                        n_state = lzu_pkg::S_BITS;
                    end
                end
            end
            lzu_pkg::S_BITS: begin
                // hold the bit while a literal waits for the output register
                if (!(w_dec.lit_next && !w_out_free)) begin
                    w_step = 1'b1;
                    n_sh   = {r_sh[6:0], 1'b0};
                    n_bits = r_bits - 4'd1;
                    if (w_dec.lit_next) begin
                        w_wr_en  = 1'b1;
                        n_ovalid = 1'b1;
                        n_obytes = {56'd0, w_dec.lit_byte};
                        n_ocnt   = 4'd1;
                        n_olast  = 1'b1;
                        n_ostat  = lzu_pkg::ST_DATA;
                    end
                    if (w_dec.match_next) begin
                        n_rem   = w_dec.len;
                        n_pk    = 64'd0;
                        n_pkn   = 3'd0;
                        n_state = lzu_pkg::S_COPY_RD;
                    end else if (r_bits == 4'd1) begin
                        n_state = lzu_pkg::S_IDLE;
                    end
                end
            end
            lzu_pkg::S_COPY_RD: begin
                w_rd_en = 1'b1;
                n_state = lzu_pkg::S_COPY_WR;
            end
            lzu_pkg::S_COPY_WR: begin
                w_wr_data = w_rd_data;
                if (!(((r_pkn == 3'd7) || (r_rem == 9'd1)) && !w_out_free)) begin
                    w_wr_en = 1'b1;
                    n_rem   = r_rem - 9'd1;
                    n_pk    = w_pk_ins;
                    n_pkn   = r_pkn + 3'd1;
                    if ((r_pkn == 3'd7) || (r_rem == 9'd1)) begin
                        n_ovalid = 1'b1;
                        n_obytes = w_pk_ins;
                        n_ocnt   = {1'b0, r_pkn} + 4'd1;
                        n_olast  = (r_rem == 9'd1);
                        n_ostat  = lzu_pkg::ST_DATA;
                        n_pk     = 64'd0;
                        n_pkn    = 3'd0;
                    end
                    if (r_rem == 9'd1) begin
                        n_state = (r_bits == 4'd0) ? lzu_pkg::S_IDLE : lzu_pkg::S_BITS;
                    end else begin
                        n_state = lzu_pkg::S_COPY_RD;
                    end
                end
            end
            lzu_pkg::S_REPORT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_obytes = 64'd0;
                    n_ocnt   = 4'd0;
                    n_olast  = 1'b1;
                    n_ostat  = r_rep;
                    n_state  = lzu_pkg::S_IDLE;
                end
            end
            default: n_state = lzu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lzu_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_old    <= 1'b0;
            r_bits   <= 4'd0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_bits   <= n_bits;
            if (i_cfg_valid && o_cfg_ready) begin
                r_old <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep    <= n_rep;
        r_sh     <= n_sh;
        r_rem    <= n_rem;
        r_pk     <= n_pk;
        r_pkn    <= n_pkn;
        r_obytes <= n_obytes;
        r_ocnt   <= n_ocnt;
        r_olast  <= n_olast;
        r_ostat  <= n_ostat;
    end

    // status beats carry no bytes and always close the code
    a_report_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != lzu_pkg::ST_DATA)) |->
        ((m_axis_tdata[67:64] == 4'd0) && m_axis_tlast))
        else $error("status beat with data or without last");

    // data beats carry at least one byte
    a_data_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == lzu_pkg::ST_DATA)) |->
        (m_axis_tdata[67:64] != 4'd0))
        else $error("empty data beat");

    // an accepted end beat leads to the report state
    a_end_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> (r_state == lzu_pkg::S_REPORT))
        else $error("end beat not reported");

endmodule

/* tb/lz_unary_code_decompressor_core_tb.sv */
// Testbench: stream-level check of the unary-code LZ decompressor core against a local predictor.
`timescale 1ns / 1ps
module lz_unary_code_decompressor_core_tb;

    localparam int HIST_DEPTH = lzu_pkg::WINDOW_SIZE_DEF;
    localparam int DRAIN_CYCLES = 700;   // longest match copy plus margin

    typedef struct {
        logic [63:0]      bytes;
        logic [3:0]       cnt;
        logic             last;
        lzu_pkg::t_status st;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    lz_unary_code_decompressor_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // decoder mirror
    logic [7:0]       hist [HIST_DEPTH];
    int unsigned      wr_pos, held, pones, mlen, mdist;
    logic [23:0]      bstore;
    lzu_pkg::t_phase  phase;
    bit               any_out, old_fmt;

    t_beat       decoded_q[$];
    bit          code_bits[$];
    int          n_fail, n_items, n_results, n_matches, n_under, n_done;
    int          burst_left;

    function automatic int unsigned take_bits(int unsigned n);
        int unsigned v;
        v = (bstore >> (held - n)) & ((1 << n) - 1);
        held -= n;
        bstore &= (held == 0) ? 24'd0 : 24'((1 << held) - 1);
        return v;
    endfunction

    function automatic void out_byte(logic [7:0] b, ref logic [7:0] q[$]);
        hist[wr_pos] = b;
        wr_pos = (wr_pos + 1) % HIST_DEPTH;
        q.push_back(b);
        any_out = 1'b1;
    endfunction

    function automatic void pack_code(logic [7:0] q[$]);
        t_beat b;
        int    p;
        p = 0;
        while (p < q.size()) begin
            b.bytes = '0;
            b.cnt = '0;
            while (b.cnt < 8 && p < q.size()) begin
                b.bytes[8*b.cnt +: 8] = q[p];
                b.cnt++;
                p++;
            end
            b.last = (p >= q.size());
            b.st = lzu_pkg::ST_DATA;
            decoded_q.push_back(b);
        end
    endfunction

    function automatic void end_report(lzu_pkg::t_status s);
        t_beat b;
        b.bytes = '0;
        b.cnt = '0;
        b.last = 1'b1;
        b.st = s;
        decoded_q.push_back(b);
    endfunction

    // advance the mirror by one accepted input beat
    function automatic void decode_beat(bit is_end, logic [7:0] d);
        logic [7:0]  obuf[$];
        bit          stop;
        int unsigned k, n, v;
        stop = 0;
        if (is_end) begin
            if (phase == lzu_pkg::PH_LEN_PREFIX || phase == lzu_pkg::PH_DONE ||
                (phase == lzu_pkg::PH_LITERAL && any_out)) begin
                phase = lzu_pkg::PH_DONE;
                end_report(lzu_pkg::ST_DONE);
                n_done++;
            end else begin
                end_report(lzu_pkg::ST_UNDERFLOW);
                n_under++;
            end
            return;
        end
        if (phase == lzu_pkg::PH_DONE) return;
        bstore = {bstore[15:0], d};
        held = (held + 8 > 24) ? 24 : held + 8;
        while (!stop) begin
            case (phase)
                lzu_pkg::PH_LEN_PREFIX: begin
                    while (pones < lzu_pkg::LEN_PREFIX_MAX && !stop) begin
                        if (held < 1) stop = 1;
                        else if (take_bits(1) == 0) break;
                        else pones++;
                    end
                    if (!stop) begin
                        if (pones >= lzu_pkg::LEN_PREFIX_MAX && old_fmt)
                            phase = lzu_pkg::PH_LEN_SKIP;
                        else if (pones == 0) phase = lzu_pkg::PH_LITERAL;
                        else phase = lzu_pkg::PH_LEN_BITS;
                    end
                end
                lzu_pkg::PH_LEN_SKIP, lzu_pkg::PH_OFF_SKIP: begin
                    if (held < 1) stop = 1;
                    else begin
                        void'(take_bits(1));
                        phase = (phase == lzu_pkg::PH_LEN_SKIP) ? lzu_pkg::PH_LEN_BITS
                                                                : lzu_pkg::PH_OFF_BITS;
                    end
                end
                lzu_pkg::PH_LEN_BITS: begin
                    k = pones;
                    if (held < k) stop = 1;
                    else begin
                        v = take_bits(k);
                        mlen = ((1 << k) - 1 + v + 2) & 9'h1FF;
                        pones = 0;
                        phase = lzu_pkg::PH_OFF_PREFIX;
                    end
                end
                lzu_pkg::PH_LITERAL: begin
                    if (held < 8) stop = 1;
                    else begin
                        obuf.delete();
                        out_byte(8'(take_bits(8)), obuf);
                        pack_code(obuf);
                        pones = 0;
                        phase = lzu_pkg::PH_LEN_PREFIX;
                    end
                end
                lzu_pkg::PH_OFF_PREFIX: begin
                    while (pones < lzu_pkg::OFF_PREFIX_MAX && !stop) begin
                        if (held < 1) stop = 1;
                        else if (take_bits(1) == 0) break;
                        else pones++;
                    end
                    if (!stop)
                        phase = (pones >= lzu_pkg::OFF_PREFIX_MAX && old_fmt) ?
                                lzu_pkg::PH_OFF_SKIP : lzu_pkg::PH_OFF_BITS;
                end
                lzu_pkg::PH_OFF_BITS: begin
                    n = lzu_pkg::OFF_BITS_BASE + pones;
                    if (held < n) stop = 1;
                    else begin
                        v = take_bits(n);
                        mdist = ((1 << n) - lzu_pkg::OFF_BIAS + v) & 14'h3FFF;
                        obuf.delete();
                        for (int i = 0; i < mlen; i++)
                            out_byte(hist[(wr_pos + 2*HIST_DEPTH - mdist - 1) % HIST_DEPTH], obuf);
                        pack_code(obuf);
                        n_matches++;
                        pones = 0;
                        phase = lzu_pkg::PH_LEN_PREFIX;
                    end
                end
                default: stop = 1;
            endcase
        end
    endfunction

    // sender: bursts with random gaps; enter and leave at a falling edge
    task automatic send_beat(bit is_end, logic [7:0] d);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= is_end;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_beat(is_end, d);
        n_items++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic hold_sender();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
    endtask

    // pause until every decoded beat came out, then let trailing bits settle
    task automatic drain_all();
        hold_sender();
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_legacy_skip(bit val);
        drain_all();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= {7'd0, val};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        old_fmt = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic void push_bits(int unsigned v, int n);
        for (int i = n - 1; i >= 0; i--) code_bits.push_back(v[i]);
    endfunction

    function automatic void gen_literal(logic [7:0] b);
        code_bits.push_back(1'b0);
        push_bits(b, 8);
    endfunction

    function automatic void gen_match(int k, int unsigned v, int j, int unsigned dv);
        push_bits('1, k);
        if (k < lzu_pkg::LEN_PREFIX_MAX) code_bits.push_back(1'b0);
        else if (old_fmt) code_bits.push_back(1'($urandom_range(0, 1)));
        push_bits(v, k);
        push_bits('1, j);
        if (j < lzu_pkg::OFF_PREFIX_MAX) code_bits.push_back(1'b0);
        else if (old_fmt) code_bits.push_back(1'($urandom_range(0, 1)));
        push_bits(dv, lzu_pkg::OFF_BITS_BASE + j);
    endfunction

    function automatic void gen_random_code();
        int k, j;
        if ($urandom_range(0, 2) == 0) gen_literal(8'($urandom));
        else begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
            j = $urandom_range(0, 4);
            gen_match(k, $urandom, j, $urandom);
        end
    endfunction

    // ship whole bytes of the bit stream; underflow ends dropped in mid-code
    task automatic ship_bits(int end_pct);
        logic [7:0] d;
        while (code_bits.size() >= 8) begin
            if ($urandom_range(0, 99) < end_pct && phase != lzu_pkg::PH_LEN_PREFIX &&
                phase != lzu_pkg::PH_LITERAL && phase != lzu_pkg::PH_DONE)
                send_beat(1'b1, 8'($urandom));
            for (int i = 0; i < 8; i++) d = {d[6:0], code_bits.pop_front()};
            send_beat(1'b0, d);
        end
    endtask

    task automatic test_directed();
        write_legacy_skip(1'b0);
        // pending literal with nothing output yet: underflow
        send_beat(1'b0, 8'h00);
        send_beat(1'b1, 8'hA5);
        code_bits.push_back(1'b1);  // completes literal 0x01
        gen_literal(8'hFF);
        gen_literal(8'h00);
        gen_match(1, 0, 0, 0);                  // shortest match, nearest source
        gen_match(7, 127, 4, 13'h1FFF);         // longest match, farthest source
        gen_match(3, 5, 2, 11'h2AA);
        ship_bits(50);
        write_legacy_skip(1'b1);
        gen_match(7, 0, 4, 0);                  // both skip bits
        gen_match(2, 3, 4, 13'h1555);
        gen_literal(8'h80);
        ship_bits(50);
    endtask

    task automatic test_random_codes(int n_beats, bit fmt);
        int start;
        write_legacy_skip(fmt);
        start = n_items;
        while (n_items - start < n_beats) begin
            if ($urandom_range(0, 9) == 0) send_beat(1'b0, 8'($urandom));   // noise
            else begin
                gen_random_code();
                ship_bits(5);
            end
            if (n_items - start > n_beats / 2 && n_items - start < n_beats / 2 + 8)
                drain_all();
        end
    endtask

    task automatic test_stream_end();
        while (phase != lzu_pkg::PH_DONE) begin
            if (phase == lzu_pkg::PH_LEN_PREFIX || (phase == lzu_pkg::PH_LITERAL && any_out))
                send_beat(1'b1, 8'h00);
            else
                send_beat(1'b0, 8'($urandom));
        end
        // done phase: data ignored, every end reports done again
        repeat (4) send_beat(1'b0, 8'($urandom));
        repeat (3) send_beat(1'b1, 8'($urandom));
    endtask

    // receiver stalls: free-running, random, then periodic
    int unsigned rx_cyc = 0;
    always @(negedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        case ((rx_cyc / 300) % 3)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= (rx_cyc % 16) >= 5;
        endcase
    end

    // compare each result beat with the oldest decoded beat
    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected beat data=%h cnt=%0d last=%b status=%0d", $time,
                         m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tlast, m_axis_tuser);
                n_fail++;
            end else begin
                e = decoded_q.pop_front();
                n_results++;
                if (m_axis_tdata[63:0] !== e.bytes) begin
                    $display("%0t: out_bytes exp %h got %h", $time, e.bytes, m_axis_tdata[63:0]);
                    n_fail++;
                end
                if (m_axis_tdata[67:64] !== e.cnt) begin
                    $display("%0t: byte_count exp %0d got %0d", $time, e.cnt, m_axis_tdata[67:64]);
                    n_fail++;
                end
                if (m_axis_tlast !== e.last) begin
                    $display("%0t: last_of_code exp %b got %b", $time, e.last, m_axis_tlast);
                    n_fail++;
                end
                if (m_axis_tuser !== e.st) begin
                    $display("%0t: status exp %0d got %0d", $time, e.st, m_axis_tuser);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < HIST_DEPTH; i++) hist[i] = 8'h00;
        wr_pos = 0; held = 0; pones = 0; mlen = 0; mdist = 0; bstore = '0;
        phase = lzu_pkg::PH_LEN_PREFIX; any_out = 0; old_fmt = 0;
        n_fail = 0; n_items = 0; n_results = 0; n_matches = 0; n_under = 0; n_done = 0;
        burst_left = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_codes(200, 1'b0);
        test_random_codes(200, 1'b1);
        test_stream_end();
        drain_all();

        $display("Covered %0d input beats, %0d result beats, %0d matches,", n_items, n_results,
                 n_matches);
        $display("%0d underflow and %0d done reports, both code formats.", n_under, n_done);
        if (n_fail == 0 && decoded_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d beats still expected", decoded_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
